// ===== rtl/pcm_fade_pkg.sv =====
package pcm_fade_pkg;

    // sample formats
    localparam logic [2:0] FMT_PASS = 3'd0;
    localparam logic [2:0] FMT_S8   = 3'd1;
    localparam logic [2:0] FMT_S16  = 3'd2;
    localparam logic [2:0] FMT_S32  = 3'd3;
    localparam logic [2:0] FMT_U8   = 3'd4;
    localparam logic [2:0] FMT_U16  = 3'd5;
    localparam logic [2:0] FMT_U32  = 3'd6;

    // item function codes
    localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
    localparam logic [1:0] FUNC_FADE_IN  = 2'd1;
    localparam logic [1:0] FUNC_FADE_OUT = 2'd2;
    localparam logic [1:0] FUNC_NOP      = 2'd3;

    // fade direction
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_IN   = 2'd1;
    localparam logic [1:0] DIR_OUT  = 2'd2;

    // how a result sample is formed
    localparam logic [1:0] KIND_ZERO  = 2'd0;
    localparam logic [1:0] KIND_RAW   = 2'd1;
    localparam logic [1:0] KIND_SCALE = 2'd2;

    // register addresses (byte address bit 2 picks the register)
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // floor(m * p / 100) == (m * ceil(p * 2^39 / 100)) >> 39 for any 32-bit m
    localparam int MAG_W       = 32;
    localparam int RECIP_SHIFT = 39;
    localparam int RECIP_W     = 40;
    localparam int RECIP_SPLIT = 20;
    localparam int PP_W        = MAG_W + RECIP_W - RECIP_SPLIT;
    localparam int SUM_W       = MAG_W + RECIP_W;

    typedef logic [RECIP_W-1:0] t_recip_tab [0:127];

    function automatic t_recip_tab build_recip_tab();
        t_recip_tab tab;
        logic [63:0] num;
        for (int p = 0; p < 128; p++) begin
            num = (64'(p) << RECIP_SHIFT) + 64'd99;
            tab[p] = RECIP_W'(num / 64'd100);
        end
        return tab;
    endfunction

    localparam t_recip_tab RECIP_TAB = build_recip_tab();

endpackage

// ===== rtl/pcm_linear_fade_unit.sv =====
// Linear fade-in / fade-out gain stage for a PCM stream. Each input transfer is
// a sample or a command; each produces exactly one result. The block takes one
// transfer per clock and delivers one result per clock when the output side is
// ready; each item is registered in stage A, stage B and the output stage.
// For the gain multiply, the sample magnitude times a 40-bit reciprocal of
// percent/100 is split into two 32x20 partial products in one registered stage,
// and summed, rounded toward zero and re-signed in the next. A stall on the
// output holds the whole pipeline. Registers: format at byte address 0x0,
// samples per one-percent step at 0x4; write them only while no transfer is
// in flight.
module pcm_linear_fade_unit
    import pcm_fade_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_func,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic [6:0]             o_gain_percent,
    output logic                   o_fade_done
);

    // configuration
    logic [2:0]            r_fmt;
    logic [COUNT_BITS-1:0] r_spp;

    // fade state
    logic [6:0]            r_pct, n_pct;
    logic [1:0]            r_dir, n_dir;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] cnt_inc;

    logic                  adv;
    logic                  accept;
    logic                  cfg_wr;

    // decode of the incoming item
    logic [1:0]            in_kind;
    logic                  in_done;
    logic                  fmt_scaled;
    logic [MAG_W-1:0]      in_word;
    logic [MAG_W-1:0]      in_ext;
    logic                  in_neg;
    logic [MAG_W-1:0]      in_mag;

    // stage A
    logic                   r_a_valid;
    logic [1:0]             r_a_kind;
    logic [MAG_W-1:0]       r_a_mag;
    logic                   r_a_neg;
    logic [2:0]             r_a_fmt;
    logic [6:0]             r_a_pct;
    logic [6:0]             r_a_gain;
    logic                   r_a_done;
    logic [SAMPLE_BITS-1:0] r_a_raw;

    // stage B
    logic [RECIP_W-1:0]     recip;
    logic                   r_b_valid;
    logic [1:0]             r_b_kind;
    logic [PP_W-1:0]        r_b_pp_hi, n_b_pp_hi;
    logic [PP_W-1:0]        r_b_pp_lo, n_b_pp_lo;
    logic                   r_b_neg;
    logic [2:0]             r_b_fmt;
    logic [6:0]             r_b_gain;
    logic                   r_b_done;
    logic [SAMPLE_BITS-1:0] r_b_raw;

    // output stage
    logic [SUM_W-1:0]       prod_sum;
    logic [MAG_W-1:0]       quot;
    logic [MAG_W-1:0]       quot_signed;
    logic [MAG_W-1:0]       quot_masked;
    logic                   r_c_valid;
    logic [SAMPLE_BITS-1:0] r_c_sample, n_c_sample;
    logic [6:0]             r_c_gain;
    logic                   r_c_done;

    // the pipeline moves as one; a full output stage that is not taken holds it
    assign adv        = !r_c_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_STEP) ? 32'(r_spp) : 32'(r_fmt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_S16;
            r_spp <= COUNT_BITS'(8820);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FORMAT: r_fmt <= pwdata[2:0];
                REG_STEP:   r_spp <= pwdata[COUNT_BITS-1:0];
            endcase
        end
    end

    // sign-extend and take the magnitude of the sample in its own format
    assign in_word = MAG_W'(i_sample_in);

    always_comb begin
        fmt_scaled = 1'b1;
        in_ext     = in_word;
        in_neg     = 1'b0;
        unique case (r_fmt)
            FMT_S8: begin
                in_ext = {{(MAG_W-8){in_word[7]}}, in_word[7:0]};
                in_neg = in_word[7];
            end
            FMT_S16: begin
                in_ext = {{(MAG_W-16){in_word[15]}}, in_word[15:0]};
                in_neg = in_word[15];
            end
            FMT_S32: begin
                in_neg = in_word[31];
            end
            FMT_U8:  in_ext = {{(MAG_W-8){1'b0}}, in_word[7:0]};
            FMT_U16: in_ext = {{(MAG_W-16){1'b0}}, in_word[15:0]};
            FMT_U32: in_ext = in_word;
            default: fmt_scaled = 1'b0;
        endcase
        in_mag = in_neg ? (~in_ext + 1'b1) : in_ext;
    end

    // fade state update at the input transfer
    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_pct   = r_pct;
        n_dir   = r_dir;
        n_cnt   = r_cnt;
        in_kind = KIND_ZERO;
        in_done = 1'b0;
        unique case (i_func)
            FUNC_FADE_IN: begin
                n_dir = DIR_IN;
                n_pct = 7'd0;
                n_cnt = '0;
            end
            FUNC_FADE_OUT: begin
                n_dir = DIR_OUT;
                n_pct = PCT_FULL;
                n_cnt = '0;
            end
            FUNC_SAMPLE: begin
                if (r_dir == DIR_NONE) begin
                    in_kind = KIND_RAW;
                end else begin
                    in_kind = fmt_scaled ? KIND_SCALE : KIND_RAW;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= r_spp) begin
                        n_cnt = '0;
                        if (r_dir == DIR_IN && r_pct < PCT_FULL) begin
                            n_pct = r_pct + 7'd1;
                            if (r_pct + 7'd1 == PCT_FULL) begin
                                n_dir = DIR_NONE;
                            end
                        end else if (r_dir == DIR_OUT && r_pct != 7'd0) begin
                            n_pct = r_pct - 7'd1;
                            if (r_pct == 7'd1) begin
                                in_done = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= PCT_FULL;
            r_dir <= DIR_NONE;
            r_cnt <= '0;
        end else if (accept) begin
            r_pct <= n_pct;
            r_dir <= n_dir;
            r_cnt <= n_cnt;
        end
    end

    // stage A: captured item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_kind <= in_kind;
            r_a_mag  <= in_mag;
            r_a_neg  <= in_neg;
            r_a_fmt  <= r_fmt;
            r_a_pct  <= r_pct;
            r_a_gain <= n_pct;
            r_a_done <= in_done;
            r_a_raw  <= i_sample_in;
        end
    end

    // stage B: partial products of magnitude times reciprocal gain
    assign recip     = RECIP_TAB[r_a_pct];
    assign n_b_pp_hi = r_a_mag * recip[RECIP_W-1:RECIP_SPLIT];
    assign n_b_pp_lo = r_a_mag * recip[RECIP_SPLIT-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_kind  <= r_a_kind;
            r_b_pp_hi <= n_b_pp_hi;
            r_b_pp_lo <= n_b_pp_lo;
            r_b_neg   <= r_a_neg;
            r_b_fmt   <= r_a_fmt;
            r_b_gain  <= r_a_gain;
            r_b_done  <= r_a_done;
            r_b_raw   <= r_a_raw;
        end
    end

    // output stage: sum, truncate toward zero, restore sign, fit to format
    assign prod_sum    = {r_b_pp_hi, {RECIP_SPLIT{1'b0}}} + SUM_W'(r_b_pp_lo);
    assign quot        = prod_sum[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
    assign quot_signed = r_b_neg ? (~quot + 1'b1) : quot;

    always_comb begin
        unique case (r_b_fmt)
            FMT_S8, FMT_U8:   quot_masked = {{(MAG_W-8){1'b0}}, quot_signed[7:0]};
            FMT_S16, FMT_U16: quot_masked = {{(MAG_W-16){1'b0}}, quot_signed[15:0]};
            default:          quot_masked = quot_signed;
        endcase
        unique case (r_b_kind)
            KIND_RAW:   n_c_sample = r_b_raw;
            KIND_SCALE: n_c_sample = quot_masked[SAMPLE_BITS-1:0];
            default:    n_c_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_sample <= n_c_sample;
            r_c_gain   <= r_b_gain;
            r_c_done   <= r_b_done;
        end
    end

    assign o_out_valid    = r_c_valid;
    assign o_sample_out   = r_c_sample;
    assign o_gain_percent = r_c_gain;
    assign o_fade_done    = r_c_done;

endmodule

// ===== rtl/pcm_fade_checker.sv =====
module pcm_fade_checker
    import pcm_fade_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_sample_out,
    input logic [6:0]             o_gain_percent,
    input logic                   o_fade_done
);

    // hold a result that was not taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sample_out) && $stable(o_gain_percent)
            && $stable(o_fade_done))
        else $error("result changed while stalled");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gain_percent <= PCT_FULL)
        else $error("gain percent above full scale");

    // a done flag only comes with the step that reaches zero
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fade_done |-> o_gain_percent == 7'd0)
        else $error("fade done with nonzero gain");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pcm_linear_fade_unit pcm_fade_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pcm_fade_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sample_out   (o_sample_out),
    .o_gain_percent (o_gain_percent),
    .o_fade_done    (o_fade_done)
);
